>>> rtl/mis_pkg.sv
// shared types and constants for the metropolis ising spin update block
// no dependencies
package mis_pkg;

	localparam int unsigned SITE_W     = 6;
	localparam int unsigned RND_W      = 16;
	localparam int unsigned DE_W       = 5;
	localparam int unsigned MAG_OUT_W  = 14;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 2'd2;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ATTEMPT = 1'b1
	} mis_op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_EVAL
	} mis_state_t;

endpackage

>>> rtl/mis_spin_eval.sv
// energy change and metropolis acceptance for one site and its four neighbors
// depends on mis_pkg
module mis_spin_eval (
	input  logic                              spin,
	input  logic [3:0]                        nb,
	input  logic                              coupling_sign,
	input  logic [mis_pkg::RND_W-1:0]         random_uniform,
	input  logic [mis_pkg::RND_W-1:0]         thr_low,
	input  logic [mis_pkg::RND_W-1:0]         thr_high,
	output logic                              accept,
	output logic signed [mis_pkg::DE_W-1:0]   energy_change
);
	import mis_pkg::*;

	logic       eff;
	logic [3:0] agree;
	logic [2:0] m;

	// eff is 1 when jsign * s is positive
	assign eff   = spin ^ coupling_sign;
	assign agree = nb ~^ {4{eff}};
	assign m     = {2'b00, agree[0]} + {2'b00, agree[1]} + {2'b00, agree[2]}
		+ {2'b00, agree[3]};

	// de = 4m - 8
	assign energy_change = $signed({m, 2'b00}) - $signed(DE_W'(8));

	always_comb begin
		case (m)
			3'd3:    accept = random_uniform < thr_low;
			3'd4:    accept = random_uniform < thr_high;
			default: accept = 1'b1;
		endcase
	end

endmodule

>>> rtl/metropolis_ising_spin_update.sv
// top level of the metropolis ising spin update block: row memory, sequencer, result registers
// depends on mis_pkg and mis_spin_eval
//
// The lattice is held as SIDE rows of SIDE spins in a row-wide memory with two
// read ports and one write port. After reset a clearing pass writes every row
// to all spins up, one row a cycle; busy stays high during it. A load item goes
// through FETCH only and an attempt through FETCH and then EVAL, because the
// attempt needs three rows (its own and the two around it) and the memory gives
// two per cycle. The row is written back as FETCH ends for a load and as EVAL
// ends for an attempt, and the result is registered at that same edge. busy is
// high while an item is at work; start is taken when busy is low. Each result
// appears for one cycle with done high, in the cycle in which start may already
// be taken again; the receiver cannot stall it.
module metropolis_ising_spin_update #(
	parameter int unsigned SIDE = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [mis_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mis_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  opcode,
	input  logic [mis_pkg::SITE_W-1:0]            site_row,
	input  logic [mis_pkg::SITE_W-1:0]            site_col,
	input  logic                                  spin_value,
	input  logic [mis_pkg::RND_W-1:0]             random_uniform,
	output logic                                  done,
	output logic                                  flipped,
	output logic                                  spin_after,
	output logic signed [mis_pkg::DE_W-1:0]       energy_change,
	output logic signed [mis_pkg::MAG_OUT_W-1:0]  magnetisation
);
	import mis_pkg::*;

	localparam int unsigned RW       = $clog2(SIDE);
	localparam int unsigned MW       = $clog2(SIDE * SIDE) + 2;
	localparam int unsigned MAGW     = (MW > MAG_OUT_W) ? MW : MAG_OUT_W;
	localparam int unsigned TAB_N    = 2 ** SITE_W;
	localparam logic [RW-1:0] LAST_ROW = RW'(SIDE - 1);

	// site reduction modulo SIDE
	logic [RW-1:0] mod_tab [TAB_N];
	for (genvar gi = 0; gi < TAB_N; gi++) begin : g_mod
		localparam int unsigned MV = gi % SIDE;
		assign mod_tab[gi] = RW'(MV);
	end

	// configuration
	logic                coupling_q;
	logic [RND_W-1:0]    thr_low_q;
	logic [RND_W-1:0]    thr_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q <= 1'b0;
			thr_low_q  <= '0;
			thr_high_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_COUPLING: coupling_q <= cfg_data[0];
				CFG_THR_LOW:  thr_low_q  <= cfg_data[RND_W-1:0];
				CFG_THR_HIGH: thr_high_q <= cfg_data[RND_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	mis_state_t          state_q, state_d;
	logic [RW-1:0]       clr_q;
	logic signed [MAGW-1:0] mag_q;
	logic                done_q;

	// item registers
	mis_op_t             op_q;
	logic [RW-1:0]       r_q;
	logic [RW-1:0]       c_q;
	logic                val_q;
	logic [RND_W-1:0]    rnd_q;
	logic                up_bit_q;

	// memory
	logic [SIDE-1:0]     mem [SIDE];
	logic [SIDE-1:0]     rd_a_q;
	logic [SIDE-1:0]     rd_b_q;
	logic [RW-1:0]       ra, rb, wa;
	logic [SIDE-1:0]     wd;
	logic                we;

	// index arithmetic
	logic [RW-1:0]       r_in, up_in, dn, lf, rt;

	assign r_in  = mod_tab[site_row];
	assign up_in = (r_in == '0) ? LAST_ROW : r_in - RW'(1);
	assign dn    = (r_q == LAST_ROW) ? '0 : r_q + RW'(1);
	assign lf    = (c_q == '0) ? LAST_ROW : c_q - RW'(1);
	assign rt    = (c_q == LAST_ROW) ? '0 : c_q + RW'(1);

	// evaluation
	logic                spin_cur;
	logic                accept;
	logic signed [DE_W-1:0] de;

	assign spin_cur = rd_a_q[c_q];

	mis_spin_eval u_eval (
		.spin           (spin_cur),
		.nb             ({rd_b_q[c_q], up_bit_q, rd_a_q[lf], rd_a_q[rt]}),
		.coupling_sign  (coupling_q),
		.random_uniform (rnd_q),
		.thr_low        (thr_low_q),
		.thr_high       (thr_high_q),
		.accept         (accept),
		.energy_change  (de)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == LAST_ROW) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_FETCH;
			ST_FETCH: state_d = (op_q == OP_LOAD) ? ST_IDLE : ST_EVAL;
			ST_EVAL:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	logic                emit;
	logic                new_spin;
	logic                res_flip;
	logic signed [DE_W-1:0] res_de;
	logic signed [MAGW-1:0] mag_delta;

	always_comb begin
		busy      = 1'b1;
		ra        = r_q;
		rb        = dn;
		we        = 1'b0;
		wa        = r_q;
		wd        = rd_a_q;
		emit      = 1'b0;
		new_spin  = spin_cur;
		res_flip  = 1'b0;
		res_de    = '0;
		mag_delta = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '1;
			end
			ST_IDLE: begin
				busy = 1'b0;
				ra   = r_in;
				rb   = up_in;
			end
			ST_FETCH: begin
				if (op_q == OP_LOAD) begin
					we        = 1'b1;
					emit      = 1'b1;
					new_spin  = val_q;
					wd[c_q]   = val_q;
					if (val_q != spin_cur) begin
						mag_delta = val_q ? MAGW'(2) : -MAGW'(2);
					end
				end
			end
			ST_EVAL: begin
				we     = 1'b1;
				emit   = 1'b1;
				res_de = de;
				if (accept) begin
					res_flip  = 1'b1;
					new_spin  = ~spin_cur;
					wd[c_q]   = ~spin_cur;
					mag_delta = spin_cur ? -MAGW'(2) : MAGW'(2);
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			mag_q   <= MAGW'(SIDE * SIDE);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + RW'(1);
			end
			if (emit) begin
				mag_q <= mag_q + mag_delta;
			end
		end
	end

	// item and result registers
	logic                flip_q;
	logic                spin_after_q;
	logic signed [DE_W-1:0] de_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q  <= mis_op_t'(opcode);
			r_q   <= r_in;
			c_q   <= mod_tab[site_col];
			val_q <= spin_value;
			rnd_q <= random_uniform;
		end
		if (state_q == ST_FETCH) begin
			up_bit_q <= rd_b_q[c_q];
		end
		if (emit) begin
			flip_q       <= res_flip;
			spin_after_q <= new_spin;
			de_q         <= res_de;
		end
	end

	// row memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	assign done          = done_q;
	assign flipped       = flip_q;
	assign spin_after    = spin_after_q;
	assign energy_change = de_q;
	assign magnetisation = mag_q[MAG_OUT_W-1:0];

endmodule

>>> dv/mis_spin_checker.sv
// checker for metropolis_ising_spin_update: keeps its own lattice, spin sum and registers,
// predicts the result of every accepted item and compares it field by field
// depends on mis_pkg
module mis_spin_checker #(
	parameter int SIDE = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [mis_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mis_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic                                  opcode,
	input  logic [mis_pkg::SITE_W-1:0]            site_row,
	input  logic [mis_pkg::SITE_W-1:0]            site_col,
	input  logic                                  spin_value,
	input  logic [mis_pkg::RND_W-1:0]             random_uniform,
	input  logic                                  done,
	input  logic                                  flipped,
	input  logic                                  spin_after,
	input  logic signed [mis_pkg::DE_W-1:0]       energy_change,
	input  logic signed [mis_pkg::MAG_OUT_W-1:0]  magnetisation,
	output int                                    fail_count,
	output int                                    pending
);
	import mis_pkg::*;

	typedef struct packed {
		logic                        flipped;
		logic                        spin_after;
		logic signed [DE_W-1:0]      energy_change;
		logic signed [MAG_OUT_W-1:0] magnetisation;
	} spin_outcome_t;

	bit               lattice [SIDE][SIDE];
	int               spin_sum;
	logic             coupling_neg;
	logic [RND_W-1:0] thr_low;
	logic [RND_W-1:0] thr_high;
	spin_outcome_t    outcome_q [$];

	function automatic int spin_of(int r, int c);
		return lattice[r][c] ? 1 : -1;
	endfunction

	function automatic spin_outcome_t predict_spin_update(mis_op_t op, int row_in, int col_in,
			logic spin, logic [RND_W-1:0] rnd);
		spin_outcome_t res;
		int r;
		int c;
		int s;
		int nsum;
		int de;
		logic take;
		r = row_in % SIDE;
		c = col_in % SIDE;
		s = spin_of(r, c);
		de = 0;
		take = 1'b0;
		if (op == OP_LOAD) begin
			spin_sum += (spin ? 1 : -1) - s;
			lattice[r][c] = spin;
		end else begin
			nsum = spin_of((r + SIDE - 1) % SIDE, c) + spin_of((r + 1) % SIDE, c)
				+ spin_of(r, (c + SIDE - 1) % SIDE) + spin_of(r, (c + 1) % SIDE);
			de = 2 * (coupling_neg ? -1 : 1) * s * nsum;
			if (de <= 0) begin
				take = 1'b1;
			end else if (de == 4) begin
				take = rnd < thr_low;
			end else begin
				take = rnd < thr_high;
			end
			if (take) begin
				spin_sum -= 2 * s;
				lattice[r][c] = ~lattice[r][c];
			end
		end
		res.flipped       = take;
		res.spin_after    = lattice[r][c];
		res.energy_change = DE_W'(de);
		res.magnetisation = MAG_OUT_W'(spin_sum);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spin_outcome_t want;
		if (!arst_n) begin
			foreach (lattice[i, j]) lattice[i][j] = 1'b1;
			spin_sum = SIDE * SIDE;
			coupling_neg = 1'b0;
			thr_low = '0;
			thr_high = '0;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (flipped !== want.flipped) begin
						$error("flipped: expected %0d, got %0d", want.flipped, flipped);
						fail_count++;
					end
					if (spin_after !== want.spin_after) begin
						$error("spin_after: expected %0d, got %0d", want.spin_after, spin_after);
						fail_count++;
					end
					if (energy_change !== want.energy_change) begin
						$error("energy_change: expected %0d, got %0d",
							want.energy_change, energy_change);
						fail_count++;
					end
					if (magnetisation !== want.magnetisation) begin
						$error("magnetisation: expected %0d, got %0d",
							want.magnetisation, magnetisation);
						fail_count++;
					end
				end
			end
			if (start && busy === 1'b0)
				outcome_q.push_back(predict_spin_update(mis_op_t'(opcode), int'(site_row),
					int'(site_col), spin_value, random_uniform));
			if (cfg_write) begin
				case (cfg_index)
					CFG_COUPLING: coupling_neg = cfg_data[0];
					CFG_THR_LOW:  thr_low = cfg_data[RND_W-1:0];
					CFG_THR_HIGH: thr_high = cfg_data[RND_W-1:0];
					default: ;
				endcase
			end
		end
		pending = outcome_q.size();
	end

endmodule

>>> dv/tb_metropolis_ising_spin_update.sv
// testbench top for metropolis_ising_spin_update: clock, reset, directed and random items,
// register settings between phases, watchdog and verdict
// depends on mis_pkg, metropolis_ising_spin_update and mis_spin_checker
module tb_metropolis_ising_spin_update;
	import mis_pkg::*;

	localparam int SIDE        = 64;
	localparam int STALL_LIMIT = 1000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = CFG_COUPLING;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         start = 1'b0;
	logic                         busy;
	logic                         opcode = OP_LOAD;
	logic [SITE_W-1:0]            site_row = '0;
	logic [SITE_W-1:0]            site_col = '0;
	logic                         spin_value = 1'b0;
	logic [RND_W-1:0]             random_uniform = '0;
	logic                         done;
	logic                         flipped;
	logic                         spin_after;
	logic signed [DE_W-1:0]       energy_change;
	logic signed [MAG_OUT_W-1:0]  magnetisation;
	int                           fail_count;
	int                           pending;
	int                           stall_cycles = 0;
	logic [RND_W-1:0]             thr_lo = '0;
	logic [RND_W-1:0]             thr_hi = '0;
	bit                           idling = 1'b1;

	metropolis_ising_spin_update #(.SIDE(SIDE)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode),
		.site_row(site_row), .site_col(site_col), .spin_value(spin_value),
		.random_uniform(random_uniform), .done(done), .flipped(flipped),
		.spin_after(spin_after), .energy_change(energy_change), .magnetisation(magnetisation)
	);

	mis_spin_checker #(.SIDE(SIDE)) u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode),
		.site_row(site_row), .site_col(site_col), .spin_value(spin_value),
		.random_uniform(random_uniform), .done(done), .flipped(flipped),
		.spin_after(spin_after), .energy_change(energy_change), .magnetisation(magnetisation),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_metropolis_ising_spin_update failed");
				$finish;
			end
		end
	end

	// all tasks start and end just after a falling edge
	task automatic send_item(mis_op_t op, logic [SITE_W-1:0] row, logic [SITE_W-1:0] col,
			logic spin, logic [RND_W-1:0] rnd);
		start <= 1'b1;
		opcode <= op;
		site_row <= row;
		site_col <= col;
		spin_value <= spin;
		random_uniform <= rnd;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	task automatic idle_cycles(int n);
		for (int i = 0; i < n; i++) begin
			start <= 1'b0;
			opcode <= 1'($urandom);
			site_row <= SITE_W'($urandom);
			site_col <= SITE_W'($urandom);
			spin_value <= 1'($urandom);
			random_uniform <= RND_W'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic maybe_gap();
		if (idling && $urandom_range(0, 99) < 19)
			idle_cycles($urandom_range(1, 6));
	endtask

	task automatic drain_results();
		do begin
			start <= 1'b0;
			@(negedge clk);
		end while (pending != 0 || busy !== 1'b0);
	endtask

	task automatic set_registers(logic coupling, logic [RND_W-1:0] lo, logic [RND_W-1:0] hi);
		thr_lo = lo;
		thr_hi = hi;
		cfg_write <= 1'b1;
		cfg_index <= CFG_COUPLING;
		cfg_data <= CFG_DATA_W'(coupling);
		@(negedge clk);
		cfg_index <= CFG_THR_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CFG_THR_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [RND_W-1:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return RND_W'($urandom);
		endcase
	endfunction

	initial begin
		mis_op_t          op;
		logic [SITE_W-1:0] row;
		logic [SITE_W-1:0] col;
		logic [SITE_W-1:0] base_row;
		logic [SITE_W-1:0] base_col;
		logic [RND_W-1:0]  rnd;
		base_row = '0;
		base_col = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: ferromagnetic, both thresholds zero
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'h0000);
		send_item(OP_LOAD, 6'd0, 6'd0, 1'b1, 16'hFFFF);
		send_item(OP_LOAD, 6'd0, 6'd63, 1'b0, 16'h0000);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b1, 16'h0000);
		send_item(OP_LOAD, 6'd0, 6'd1, 1'b0, 16'h1234);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'hFFFF);
		send_item(OP_LOAD, 6'd63, 6'd0, 1'b0, 16'h0000);
		send_item(OP_LOAD, 6'd1, 6'd0, 1'b0, 16'h0000);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b1, 16'hFFFF);
		send_item(OP_LOAD, 6'd0, 6'd0, 1'b1, 16'h0000);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'h8000);
		send_item(OP_LOAD, 6'd63, 6'd63, 1'b0, 16'h0000);
		send_item(OP_LOAD, 6'd42, 6'd21, 1'b0, 16'h5555);
		drain_results();

		// antiferromagnetic with thresholds at the top: strict less-than at the edge
		set_registers(1'b1, 16'hFFFF, 16'hFFFF);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'h0000);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'hFFFF);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'hFFFE);
		send_item(OP_LOAD, 6'd0, 6'd63, 1'b1, 16'h0000);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'hFFFF);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'hFFFF);
		send_item(OP_ATTEMPT, 6'd0, 6'd0, 1'b0, 16'hFFFE);
		send_item(OP_ATTEMPT, 6'd63, 6'd63, 1'b0, 16'h0001);
		send_item(OP_ATTEMPT, 6'd21, 6'd42, 1'b1, 16'h7FFF);
		drain_results();

		// sweep two rows down, no idling
		set_registers(1'b0, 16'h0001, 16'h8000);
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < SIDE; c++)
				send_item(OP_LOAD, SITE_W'(r), SITE_W'(c), 1'b0, RND_W'($urandom));
		send_item(OP_ATTEMPT, 6'd10, 6'd10, 1'b0, 16'h0000);
		drain_results();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_registers(1'b0, 16'hFFFF, 16'h0000);
				1: set_registers(1'b1, 16'h0000, 16'hFFFF);
				default: set_registers(1'($urandom_range(0, 1)), pick_threshold(),
					pick_threshold());
			endcase
			idling = (p != 3);
			for (int i = 0; i < 135; i++) begin
				if (i % 40 == 0) begin
					base_row = ($urandom_range(0, 3) == 0) ? 6'd62 : SITE_W'($urandom);
					base_col = ($urandom_range(0, 3) == 0) ? 6'd62 : SITE_W'($urandom);
				end
				if ($urandom_range(0, 9) < 7) begin
					row = base_row + SITE_W'($urandom_range(0, 3));
					col = base_col + SITE_W'($urandom_range(0, 3));
				end else begin
					row = SITE_W'($urandom);
					col = SITE_W'($urandom);
				end
				op = ($urandom_range(0, 9) < 6) ? OP_ATTEMPT : OP_LOAD;
				case ($urandom_range(0, 3))
					0: rnd = thr_lo - RND_W'($urandom_range(0, 1));
					1: rnd = thr_hi - RND_W'($urandom_range(0, 1));
					default: rnd = RND_W'($urandom);
				endcase
				maybe_gap();
				send_item(op, row, col, 1'($urandom), rnd);
				if (p == 2 && i == 80)
					drain_results();
			end
			drain_results();
		end

		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_metropolis_ising_spin_update passed");
		end else begin
			$display("tb_metropolis_ising_spin_update failed");
		end
		$finish;
	end

endmodule
